/* sv/uv_sphere_vertex_generator_top_macros.svh */
// Assertion macros for the UV sphere vertex generator.
// Used by uv_sphere_vertex_generator_top; expects clk_i and rst_ni in scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define UVSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UVSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/uvsg_pkg.sv */
// Shared types and constants for the UV sphere vertex generator.
// No dependencies.
package uvsg_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned LON_BITS   = 17;
  localparam int unsigned PHASE_BITS = 17;
  localparam int unsigned TEX_BITS   = 17;
  localparam int unsigned QUO_BITS   = 18;
  localparam int unsigned REM_BITS   = 26;
  localparam int unsigned CNT_BITS   = 9;
  localparam int unsigned NUM_LANES  = 3;

  localparam int unsigned LANE_LON  = 0;
  localparam int unsigned LANE_TEXU = 1;
  localparam int unsigned LANE_LAT  = 2;

  localparam logic [1:0] REG_SLICE = 2'd0;
  localparam logic [1:0] REG_STACK = 2'd1;
  localparam logic [1:0] REG_COLOR = 2'd2;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [CNT_BITS-1:0] den;
    logic [QUO_BITS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic valid;
    logic err;
    logic last;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [TEX_BITS-1:0] tex_u;
    logic [TEX_BITS-1:0] tex_v;
  } tail_t;

endpackage

/* sv/uvsg_if.sv */
// Channel interfaces of the UV sphere vertex generator: config, request, vertex.
// Depends on nothing.
interface uvsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface uvsg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stack_row;
  logic [8:0] slice_column;
  modport source (output valid, stack_row, slice_column, input ready);
  modport sink (input valid, stack_row, slice_column, output ready);
endinterface

interface uvsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [31:0]        color_out;
  logic               range_error;
  logic               last_of_pair;
  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tex_u, tex_v, color_out, range_error, last_of_pair, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                tex_u, tex_v, color_out, range_error, last_of_pair, output ready);
endinterface

/* sv/uvsg_div_cell.sv */
// One quotient bit of the restoring divider chain, for all three divide lanes.
// Depends on uvsg_pkg.
module uvsg_div_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  uvsg_pkg::side_t                            side_i,
  input  uvsg_pkg::div_lane_t [uvsg_pkg::NUM_LANES-1:0] lane_i,
  output uvsg_pkg::side_t                            side_o,
  output uvsg_pkg::div_lane_t [uvsg_pkg::NUM_LANES-1:0] lane_o
);
  import uvsg_pkg::*;

  side_t                       side_q;
  div_lane_t [NUM_LANES-1:0]   lane_d, lane_q;
  logic [REM_BITS:0]           diff [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_d[i] = lane_i[i];
      diff[i] = {1'b0, lane_i[i].rem} - {1'b0, (REM_BITS'(lane_i[i].den) << STEP)};
      if (!diff[i][REM_BITS]) begin
        lane_d[i].rem       = diff[i][REM_BITS-1:0];
        lane_d[i].quo[STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign side_o = side_q;
  assign lane_o = lane_q;

endmodule

/* sv/uvsg_sine.sv */
// Four-stage fixed-point sine of a 17-bit phase, Q14 result.
// Depends on uvsg_pkg.
module uvsg_sine (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [uvsg_pkg::PHASE_BITS-1:0]   phase_i,
  output logic signed [15:0]                sin_o
);
  import uvsg_pkg::*;

  logic [15:0] x_in;
  logic [31:0] xx, m2, m3, m4;
  logic [15:0] s4;

  logic [1:0]  q1_q, q2_q, q3_q;
  logic [15:0] x1_q, x2_q, x3_q;
  logic [15:0] xsq1_q, xsq2_q;
  logic [14:0] t1_q;
  logic [15:0] t2_q;
  logic signed [15:0] sin_q;

  always_comb begin
    x_in = phase_i[15] ? 16'(17'd32768 - {2'b0, phase_i[14:0]})
                       : {1'b0, phase_i[14:0]};
    xx   = 32'(x_in) * 32'(x_in);
    m2   = (32'd2320 * 32'(xsq1_q)) >> 15;
    m3   = (32'(t1_q) * 32'(xsq2_q)) >> 15;
    m4   = (32'(x3_q) * 32'(t2_q) + 32'd32768) >> 16;
    s4   = m4[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q   <= phase_i[16:15];
      x1_q   <= x_in;
      xsq1_q <= xx[30:15];
      q2_q   <= q1_q;
      x2_q   <= x1_q;
      xsq2_q <= xsq1_q;
      t1_q   <= 15'(32'd21024 - m2);
      q3_q   <= q2_q;
      x3_q   <= x2_q;
      t2_q   <= 16'(32'd51472 - m3);
      sin_q  <= q3_q[1] ? -$signed(s4) : $signed(s4);
    end
  end

  assign sin_o = sin_q;

endmodule

/* sv/uv_sphere_vertex_generator_top.sv */
// Each accepted request (stack row, slice column) yields two vertex transfers,
// upper ring then lower ring, so a new request is taken only as the previous one's
// lower vertex leaves the front register while the output flows. The pace is set
// by the single vertex lane: each vertex passes an 18-cell divider chain, a 4-stage
// sine unit, one multiply stage and the output register. Config writes take effect
// at once, no clearing.
`include "uv_sphere_vertex_generator_top_macros.svh"
module uv_sphere_vertex_generator_top #(
  parameter int unsigned MAX_DIVISIONS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uvsg_cfg_if.sink  cfg_i,
  uvsg_in_if.sink   in_i,
  uvsg_out_if.source out_o
);
  import uvsg_pkg::*;

  function automatic logic [15:0] round_sh(input logic signed [31:0] v,
                                           input int unsigned sh);
    logic [31:0] mag;
    logic [31:0] r;
    mag = v[31] ? 32'(-v) : 32'(v);
    r   = (mag + (32'd1 << (sh - 1))) >> sh;
    return v[31] ? 16'(-r) : 16'(r);
  endfunction

  logic [CNT_BITS-1:0] slice_q, stack_q;
  logic [31:0]         color_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= 9'd16;
      stack_q <= 9'd16;
      color_q <= 32'hFFFF_FFFF;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SLICE: slice_q <= cfg_i.data[CNT_BITS-1:0];
        REG_STACK: stack_q <= cfg_i.data[CNT_BITS-1:0];
        REG_COLOR: color_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic adv, out_valid_q, in_fire;
  logic front_valid_q, front_last_q;
  logic [7:0] front_row_q;
  logic [8:0] front_col_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !front_valid_q || (adv && front_last_q);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
      front_last_q  <= 1'b0;
    end else if (in_fire) begin
      front_valid_q <= 1'b1;
      front_last_q  <= 1'b0;
    end else if (adv && front_valid_q) begin
      if (front_last_q) begin
        front_valid_q <= 1'b0;
      end else begin
        front_last_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      front_row_q <= in_i.stack_row;
      front_col_q <= in_i.slice_column;
    end
  end

  // Divider chain feed.
  side_t                     side_c [QUO_BITS+1];
  div_lane_t [NUM_LANES-1:0] lane_c [QUO_BITS+1];
  logic                      front_err;
  logic [8:0]                ring;

  always_comb begin
    ring      = {1'b0, front_row_q} + 9'(front_last_q);
    front_err = (slice_q == '0) || (32'(slice_q) > MAX_DIVISIONS) ||
                (stack_q == '0) || (32'(stack_q) > MAX_DIVISIONS) ||
                ({1'b0, front_row_q} >= stack_q) || (front_col_q > slice_q);
    side_c[0] = '{valid: front_valid_q, err: front_err, last: front_last_q};
    lane_c[0][LANE_LON]  = '{rem: (REM_BITS'(front_col_q) << LON_BITS) +
                                  REM_BITS'(slice_q >> 1),
                             den: slice_q, quo: '0};
    lane_c[0][LANE_TEXU] = '{rem: (REM_BITS'(front_col_q) << COORD_BITS) +
                                  REM_BITS'(slice_q >> 1),
                             den: slice_q, quo: '0};
    lane_c[0][LANE_LAT]  = '{rem: (REM_BITS'(ring) << COORD_BITS) +
                                  REM_BITS'(stack_q >> 1),
                             den: stack_q, quo: '0};
  end

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
    uvsg_div_cell #(.STEP(QUO_BITS - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .side_i (side_c[g]),
      .lane_i (lane_c[g]),
      .side_o (side_c[g+1]),
      .lane_o (lane_c[g+1])
    );
  end

  logic [PHASE_BITS-1:0] lon_ph, lat_ph;
  logic signed [15:0]    sa, ca, cb, sb;

  assign lon_ph = lane_c[QUO_BITS][LANE_LON].quo[PHASE_BITS-1:0];
  assign lat_ph = lane_c[QUO_BITS][LANE_LAT].quo[PHASE_BITS-1:0];

  uvsg_sine u_sa (.clk_i(clk_i), .en_i(adv), .phase_i(lon_ph), .sin_o(sa));
  uvsg_sine u_ca (.clk_i(clk_i), .en_i(adv), .phase_i(lon_ph + 17'h08000), .sin_o(ca));
  uvsg_sine u_cb (.clk_i(clk_i), .en_i(adv), .phase_i(lat_ph), .sin_o(cb));
  uvsg_sine u_sb (.clk_i(clk_i), .en_i(adv), .phase_i(lat_ph + 17'h08000), .sin_o(sb));

  tail_t              tail_q [4];
  tail_t              tail_p_q;
  logic signed [31:0] px_q, pz_q;
  logic signed [15:0] sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        tail_q[i] <= '0;
      end
      tail_p_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      tail_q[0] <= '{side: side_c[QUO_BITS],
                     tex_u: lane_c[QUO_BITS][LANE_TEXU].quo[TEX_BITS-1:0],
                     tex_v: lane_c[QUO_BITS][LANE_LAT].quo[TEX_BITS-1:0]};
      for (int i = 1; i < 4; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
      tail_p_q    <= tail_q[3];
      out_valid_q <= tail_p_q.side.valid;
    end
  end

  logic [15:0] px_o_q, py_o_q, pz_o_q, nx_o_q, ny_o_q, nz_o_q;
  logic [16:0] tu_o_q, tv_o_q;
  logic [31:0] col_o_q;
  logic        err_o_q, last_o_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q     <= sa * cb;
      pz_q     <= ca * cb;
      sb_q     <= sb;
      err_o_q  <= tail_p_q.side.err;
      last_o_q <= tail_p_q.side.last;
      if (tail_p_q.side.err) begin
        px_o_q  <= '0;
        py_o_q  <= '0;
        pz_o_q  <= '0;
        nx_o_q  <= '0;
        ny_o_q  <= '0;
        nz_o_q  <= '0;
        tu_o_q  <= '0;
        tv_o_q  <= '0;
        col_o_q <= '0;
      end else begin
        px_o_q  <= round_sh(px_q, 15);
        py_o_q  <= round_sh(32'(sb_q), 1);
        pz_o_q  <= round_sh(pz_q, 15);
        nx_o_q  <= round_sh(px_q, 14);
        ny_o_q  <= sb_q;
        nz_o_q  <= round_sh(pz_q, 14);
        tu_o_q  <= tail_p_q.tex_u;
        tv_o_q  <= tail_p_q.tex_v;
        col_o_q <= color_q;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pos_x        = px_o_q;
  assign out_o.pos_y        = py_o_q;
  assign out_o.pos_z        = pz_o_q;
  assign out_o.normal_x     = nx_o_q;
  assign out_o.normal_y     = ny_o_q;
  assign out_o.normal_z     = nz_o_q;
  assign out_o.tex_u        = tu_o_q;
  assign out_o.tex_v        = tv_o_q;
  assign out_o.color_out    = col_o_q;
  assign out_o.range_error  = err_o_q;
  assign out_o.last_of_pair = last_o_q;

  `UVSG_ASSERT_NOW(a_err_zero, out_o.valid && out_o.range_error, out_o.pos_x == 16'sd0 && out_o.tex_u == 17'd0 && out_o.color_out == 32'd0, "error vertex carries data")
  `UVSG_ASSERT_NOW(a_tex_range, out_o.valid, out_o.tex_u <= 17'd65536 && out_o.tex_v <= 17'd65536, "texture coordinate above one")
  `UVSG_ASSERT_NEXT(a_pair_start, in_i.valid && in_i.ready, front_valid_q && !front_last_q, "request did not start with upper vertex")

endmodule
